>>> src/dap_pkg.sv
// shared types and constants for the dns a-record reply parser
package dap_pkg;

  // apb address width: three 32-bit registers at byte offsets 0, 4 and 8
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam int unsigned ID_W   = 16;
  localparam int unsigned TTL_W  = 32;
  localparam int unsigned ADDR_W = 32;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_EXPECTED_ID = 2'd0;
  localparam logic [1:0] REG_TTL_FLOOR   = 2'd1;
  localparam logic [1:0] REG_TTL_CEILING = 2'd2;

  // register reset values
  localparam logic [ID_W-1:0]  EXPECTED_ID_RST = 16'd0;
  localparam logic [TTL_W-1:0] TTL_FLOOR_RST   = 32'd30;
  localparam logic [TTL_W-1:0] TTL_CEILING_RST = 32'd3600;

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_BAD_ID    = 3'd1,
    ST_NOT_RESP  = 3'd2,
    ST_RCODE     = 3'd3,
    ST_MALFORMED = 3'd4,
    ST_NO_A      = 3'd5,
    ST_UNDECIDED = 3'd7
  } status_e;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] address;
    logic [TTL_W-1:0]  ttl;
  } result_t;

endpackage

>>> src/dns_a_response_parser_top.sv
// top level of the dns a-record reply parser: input stage, apb registers, result register
//
// takes a dns reply one byte per transfer and, on the byte marked last, delivers one
// result: status, ipv4 address and clamped ttl of the first answer with class in,
// type a and data length 4. the header id is checked against expected_id, the
// response flag and a zero rcode are required, names are skipped (compression
// pointers end a name and are not followed). a new byte is taken every cycle;
// the only stall is a last byte whose result cannot move because the previous
// result still waits in the output register. the result is registered as the last
// byte leaves the input stage. ttl_floor is applied before ttl_ceiling, so the
// ceiling wins when they cross. registers sit on an apb port: expected_id at 0x0,
// ttl_floor at 0x4, ttl_ceiling at 0x8; write them only while no message is in flight
module dns_a_response_parser_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // byte stream
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  data_byte_i,
  input  logic                        last_byte_i,
  // verdict
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  status_o,
  output logic [dap_pkg::ADDR_W-1:0]  address_o,
  output logic [dap_pkg::TTL_W-1:0]   ttl_out_o,
  // apb register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dap_pkg::PADDR_W-1:0] paddr,
  input  logic [dap_pkg::PDATA_W-1:0] pwdata,
  output logic [dap_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  logic [dap_pkg::ID_W-1:0]  expected_id_q;
  logic [dap_pkg::TTL_W-1:0] ttl_floor_q;
  logic [dap_pkg::TTL_W-1:0] ttl_ceiling_q;
  logic                      cfg_we;
  logic [1:0]                reg_idx;

  // input stage
  logic                      s1_valid_q;
  logic [7:0]                s1_byte_q;
  logic                      s1_last_q;
  logic                      s1_go;

  // output register
  logic                      out_valid_q;
  logic                      out_free;
  dap_pkg::result_t          res;
  dap_pkg::result_t          out_res_q;

  // ---------------- register port ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite;

  always_comb begin
    unique case (reg_idx)
      dap_pkg::REG_EXPECTED_ID: prdata = {{(dap_pkg::PDATA_W - dap_pkg::ID_W){1'b0}},
                                          expected_id_q};
      dap_pkg::REG_TTL_FLOOR:   prdata = ttl_floor_q;
      dap_pkg::REG_TTL_CEILING: prdata = ttl_ceiling_q;
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_id_q <= dap_pkg::EXPECTED_ID_RST;
      ttl_floor_q   <= dap_pkg::TTL_FLOOR_RST;
      ttl_ceiling_q <= dap_pkg::TTL_CEILING_RST;
    end else if (cfg_we) begin
      unique case (reg_idx)
        dap_pkg::REG_EXPECTED_ID: expected_id_q <= pwdata[dap_pkg::ID_W-1:0];
        dap_pkg::REG_TTL_FLOOR:   ttl_floor_q   <= pwdata;
        dap_pkg::REG_TTL_CEILING: ttl_ceiling_q <= pwdata;
        default: ;  // unmapped offset, write dropped
      endcase
    end
  end

  // ---------------- flow control ----------------
  // a byte leaves the input stage unless it is a last byte facing a full output
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_go      = s1_valid_q && (!s1_last_q || out_free);
  assign in_ready_o = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  // ---------------- parser ----------------
  dap_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (s1_go),
    .byte_i        (s1_byte_q),
    .last_i        (s1_last_q),
    .expected_id_i (expected_id_q),
    .ttl_floor_i   (ttl_floor_q),
    .ttl_ceiling_i (ttl_ceiling_q),
    .res_o         (res)
  );

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_last_q) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_res_q.status;
  assign address_o   = out_res_q.address;
  assign ttl_out_o   = out_res_q.ttl;

endmodule

>>> src/dap_parser.sv
// byte-wise dns reply walker: header checks, name skipping and answer record decode
module dap_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [7:0]                byte_i,
  input  logic                      last_i,
  input  logic [dap_pkg::ID_W-1:0]  expected_id_i,
  input  logic [dap_pkg::TTL_W-1:0] ttl_floor_i,
  input  logic [dap_pkg::TTL_W-1:0] ttl_ceiling_i,
  output dap_pkg::result_t          res_o
);

  typedef enum logic [3:0] {
    PH_HEADER = 4'd0,
    PH_QNAME  = 4'd1,
    PH_QLABEL = 4'd2,
    PH_QPTR   = 4'd3,
    PH_QFIXED = 4'd4,
    PH_ANAME  = 4'd5,
    PH_ALABEL = 4'd6,
    PH_APTR   = 4'd7,
    PH_AFIXED = 4'd8,
    PH_ARDATA = 4'd9,
    PH_DONE   = 4'd10
  } phase_e;

  phase_e                    phase_q, phase_d;
  dap_pkg::status_e          verdict_q, verdict_d;
  logic [3:0]                fpos_q, fpos_d;
  logic [15:0]               qleft_q, qleft_d;
  logic [15:0]               aleft_q, aleft_d;
  logic [5:0]                lbl_q, lbl_d;
  logic [15:0]               rdlen_q, rdlen_d;
  logic [15:0]               rtype_q, rtype_d;
  logic [15:0]               rclass_q, rclass_d;
  logic [dap_pkg::TTL_W-1:0] rttl_q, rttl_d;
  logic [dap_pkg::ADDR_W-1:0] addr_q, addr_d;
  logic [7:0]                id_hi_q, id_hi_d;

  logic                      is_q_sect;
  logic                      match;
  logic [dap_pkg::TTL_W-1:0] ttl_lo;
  logic [dap_pkg::TTL_W-1:0] ttl_clamped;
  dap_pkg::status_e          status;

  assign is_q_sect   = (phase_q == PH_QNAME) || (phase_q == PH_QLABEL);
  assign match       = (rtype_q == 16'd1) && (rclass_q == 16'd1);
  // floor first, then ceiling
  assign ttl_lo      = (rttl_q < ttl_floor_i) ? ttl_floor_i : rttl_q;
  assign ttl_clamped = (ttl_lo > ttl_ceiling_i) ? ttl_ceiling_i : ttl_lo;

  always_comb begin
    phase_d   = phase_q;
    verdict_d = verdict_q;
    fpos_d    = fpos_q;
    qleft_d   = qleft_q;
    aleft_d   = aleft_q;
    lbl_d     = lbl_q;
    rdlen_d   = rdlen_q;
    rtype_d   = rtype_q;
    rclass_d  = rclass_q;
    rttl_d    = rttl_q;
    addr_d    = addr_q;
    id_hi_d   = id_hi_q;

    unique case (phase_q)
      PH_HEADER: begin
        unique case (fpos_q)
          4'd0: id_hi_d = byte_i;
          4'd1: begin
            if ({id_hi_q, byte_i} != expected_id_i) verdict_d = dap_pkg::ST_BAD_ID;
          end
          4'd2: begin
            if (verdict_q == dap_pkg::ST_UNDECIDED && !byte_i[7]) begin
              verdict_d = dap_pkg::ST_NOT_RESP;
            end
          end
          4'd3: begin
            if (verdict_q == dap_pkg::ST_UNDECIDED && byte_i[3:0] != 4'd0) begin
              verdict_d = dap_pkg::ST_RCODE;
            end
          end
          4'd4: qleft_d = {byte_i, 8'd0};
          4'd5: qleft_d = {qleft_q[15:8], byte_i};
          4'd6: aleft_d = {byte_i, 8'd0};
          4'd7: aleft_d = {aleft_q[15:8], byte_i};
          default: ;
        endcase
        if (fpos_q >= 4'd11) begin
          fpos_d = 4'd0;
          if (verdict_q != dap_pkg::ST_UNDECIDED) begin
            phase_d = PH_DONE;
          end else if (qleft_q != 16'd0) begin
            phase_d = PH_QNAME;
          end else if (aleft_q == 16'd0) begin
            verdict_d = dap_pkg::ST_NO_A;
            phase_d   = PH_DONE;
          end else begin
            phase_d = PH_ANAME;
          end
        end else begin
          fpos_d = fpos_q + 4'd1;
        end
      end

      PH_QNAME, PH_ANAME: begin
        if (byte_i == 8'd0) begin
          phase_d = is_q_sect ? PH_QFIXED : PH_AFIXED;
          fpos_d  = 4'd0;
        end else if (byte_i[7:6] == 2'b11) begin
          // compression pointer: one more byte, never followed
          phase_d = is_q_sect ? PH_QPTR : PH_APTR;
        end else if (byte_i > 8'd63) begin
          verdict_d = dap_pkg::ST_MALFORMED;
          phase_d   = PH_DONE;
        end else begin
          lbl_d   = byte_i[5:0];
          phase_d = is_q_sect ? PH_QLABEL : PH_ALABEL;
        end
      end

      PH_QLABEL, PH_ALABEL: begin
        lbl_d = lbl_q - 6'd1;
        if (lbl_d == 6'd0) phase_d = is_q_sect ? PH_QNAME : PH_ANAME;
      end

      PH_QPTR: begin
        phase_d = PH_QFIXED;
        fpos_d  = 4'd0;
      end

      PH_APTR: begin
        phase_d = PH_AFIXED;
        fpos_d  = 4'd0;
      end

      PH_QFIXED: begin
        if (fpos_q >= 4'd3) begin
          fpos_d  = 4'd0;
          qleft_d = qleft_q - 16'd1;
          if (qleft_d != 16'd0) begin
            phase_d = PH_QNAME;
          end else if (aleft_q == 16'd0) begin
            verdict_d = dap_pkg::ST_NO_A;
            phase_d   = PH_DONE;
          end else begin
            phase_d = PH_ANAME;
          end
        end else begin
          fpos_d = fpos_q + 4'd1;
        end
      end

      PH_AFIXED: begin
        unique case (fpos_q)
          4'd0: rtype_d  = {byte_i, 8'd0};
          4'd1: rtype_d  = {rtype_q[15:8], byte_i};
          4'd2: rclass_d = {byte_i, 8'd0};
          4'd3: rclass_d = {rclass_q[15:8], byte_i};
          4'd4, 4'd5, 4'd6, 4'd7: rttl_d = {rttl_q[23:0], byte_i};
          4'd8: rdlen_d  = {byte_i, 8'd0};
          default: rdlen_d = {rdlen_q[15:8], byte_i};
        endcase
        if (fpos_q >= 4'd9) begin
          fpos_d = 4'd0;
          if (rdlen_d != 16'd4) rtype_d = 16'd0;
          addr_d = '0;
          if (rdlen_d == 16'd0) begin
            aleft_d = aleft_q - 16'd1;
            if (aleft_d == 16'd0) begin
              verdict_d = dap_pkg::ST_NO_A;
              phase_d   = PH_DONE;
            end else begin
              phase_d = PH_ANAME;
            end
          end else begin
            phase_d = PH_ARDATA;
          end
        end else begin
          fpos_d = fpos_q + 4'd1;
        end
      end

      PH_ARDATA: begin
        if (match) addr_d = {addr_q[23:0], byte_i};
        rdlen_d = rdlen_q - 16'd1;
        if (rdlen_d == 16'd0) begin
          if (match) begin
            rttl_d    = ttl_clamped;
            verdict_d = dap_pkg::ST_FOUND;
            phase_d   = PH_DONE;
          end else begin
            addr_d  = '0;
            aleft_d = aleft_q - 16'd1;
            if (aleft_d == 16'd0) begin
              verdict_d = dap_pkg::ST_NO_A;
              phase_d   = PH_DONE;
            end else begin
              phase_d = PH_ANAME;
            end
          end
        end
      end

      default: ;
    endcase
  end

  // verdict for a message ending on this byte
  always_comb begin
    if (phase_d == PH_HEADER || verdict_d == dap_pkg::ST_UNDECIDED) begin
      status = dap_pkg::ST_MALFORMED;
    end else begin
      status = verdict_d;
    end
    res_o.status  = status;
    res_o.address = (status == dap_pkg::ST_FOUND) ? addr_d : '0;
    res_o.ttl     = (status == dap_pkg::ST_FOUND) ? rttl_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      verdict_q <= dap_pkg::ST_UNDECIDED;
      fpos_q    <= '0;
      qleft_q   <= '0;
      aleft_q   <= '0;
      lbl_q     <= '0;
      rdlen_q   <= '0;
      rtype_q   <= '0;
      rclass_q  <= '0;
      rttl_q    <= '0;
      addr_q    <= '0;
      id_hi_q   <= '0;
    end else if (step_i) begin
      if (last_i) begin
        phase_q   <= PH_HEADER;
        verdict_q <= dap_pkg::ST_UNDECIDED;
        fpos_q    <= '0;
        qleft_q   <= '0;
        aleft_q   <= '0;
        lbl_q     <= '0;
        rdlen_q   <= '0;
        rtype_q   <= '0;
        rclass_q  <= '0;
        rttl_q    <= '0;
        addr_q    <= '0;
        id_hi_q   <= '0;
      end else begin
        phase_q   <= phase_d;
        verdict_q <= verdict_d;
        fpos_q    <= fpos_d;
        qleft_q   <= qleft_d;
        aleft_q   <= aleft_d;
        lbl_q     <= lbl_d;
        rdlen_q   <= rdlen_d;
        rtype_q   <= rtype_d;
        rclass_q  <= rclass_d;
        rttl_q    <= rttl_d;
        addr_q    <= addr_d;
        id_hi_q   <= id_hi_d;
      end
    end
  end

endmodule

>>> src/dap_checker.sv
// port-level checks for the dns a-record reply parser, bound to the top level
module dap_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [2:0]                  status_o,
  input logic [dap_pkg::ADDR_W-1:0]  address_o,
  input logic [dap_pkg::TTL_W-1:0]   ttl_out_o,
  input logic                        pready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(address_o) && $stable(ttl_out_o))
    else $error("result changed while stalled");

  // address and ttl are zero unless a record was found
  a_zero_unless_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != dap_pkg::ST_FOUND |-> address_o == '0 && ttl_out_o == '0)
    else $error("address or ttl set without a found record");

  // only defined status codes leave the block
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= dap_pkg::ST_NO_A)
    else $error("undefined status code delivered");

  // register port never waits
  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("register port not ready");

endmodule

bind dns_a_response_parser_top dap_checker u_dap_checker (.*);
